@@ src/pcgb_pkg.sv @@
// Package for the pixel contrast/gamma/brightness core: constants, types, helpers.
`timescale 1ns / 1ps
`default_nettype none
package pcgb_pkg;

	localparam int CH_W = 8;
	localparam int TBL_DEPTH = 1 << CH_W;

	localparam logic [CH_W-1:0] CH_MAX = CH_W'((1 << CH_W) - 1);
	localparam logic [CH_W-1:0] OPAQUE_ALPHA = CH_MAX;
	localparam logic signed [9:0] CONTRAST_MID = 10'sd127;
	localparam logic [8:0] NEUTRAL_CONTRAST = 9'd100;
	localparam logic [9:0] NEUTRAL_GAMMA = 10'd100;

	// ceil(2^32 / 100); exact floor(m / 100) for m below 2^17
	localparam logic [25:0] RECIP_100 = 26'd42949673;

	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	typedef struct packed {
		logic advance;
		logic con_bypass;
		logic gam_bypass;
		logic [8:0] gain;
		logic signed [9:0] bright_add;
	} chan_ctrl_t;

	typedef struct packed {
		logic en;
		logic [CH_W-1:0] addr;
		logic [CH_W-1:0] data;
	} tbl_wr_t;

	function automatic logic [9:0] div100(input logic [16:0] m);
		logic [42:0] p;
		p = {26'd0, m} * {17'd0, RECIP_100};
		return p[41:32];
	endfunction

endpackage
`default_nettype wire

@@ src/pixel_contrast_gamma_brightness_core.sv @@
// Top level: stream ports, config registers, control pipeline, output register.
//
// channel   dir  width  contents
// s_axis    in   40+1   tdata: red, green, blue, table index, table value; tuser: operation
// m_axis    out  32     tdata: red, green, blue, alpha
// cfg       in   2+10   register write: index, data
//
// One transaction per clock while m_axis is not stalled; a pixel passes the input, product,
// contrast, table read and output registers. Depth is set by the contrast multiply, the
// divide-by-100 multiply and the gamma table read (synchronous memory, one copy per channel).
// Table writes travel the same pipeline and land at the lookup stage; they emit nothing.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
// Reset clears valid bits and restores neutral settings; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module pixel_contrast_gamma_brightness_core
	import pcgb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [39:0]          s_axis_tdata,  // in_red, in_green, in_blue, table_index, table_value
	input  wire logic                 s_axis_tuser,  // operation
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [8:0] contrast_gain_q;
	logic [9:0] gamma_setting_q;
	logic signed [9:0] bright_add_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic pix_s1, pix_s2, pix_s3, pix_s4;
	logic [CH_W-1:0] idx_s1, idx_s2, idx_s3, val_s1, val_s2, val_s3;
	logic m_valid_q;
	logic [CH_W-1:0] red_s5, green_s5, blue_s5;
	logic [CH_W-1:0] red_res, green_res, blue_res;

	logic advance;
	chan_ctrl_t ctrl;
	tbl_wr_t wr;

	logic [CH_W-1:0] b_mag;
	logic [9:0] b_quo;
	logic signed [10:0] b_add_nxt;

	assign advance = !m_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	// trunc(b * 255 / 100), worked out once per register write
	always_comb begin
		b_mag = cfg_data[7] ? CH_W'(-$signed(cfg_data[7:0])) : cfg_data[7:0];
		b_quo = div100({9'd0, b_mag} * 17'd255);
		b_add_nxt = cfg_data[7] ? -$signed({1'b0, b_quo}) : $signed({1'b0, b_quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_gain_q <= NEUTRAL_CONTRAST;
			gamma_setting_q <= NEUTRAL_GAMMA;
			bright_add_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CONTRAST: contrast_gain_q <= cfg_data[8:0];
				CFG_GAMMA:    gamma_setting_q <= cfg_data;
				CFG_BRIGHT:   bright_add_q <= 10'(b_add_nxt);
				default:      ;
			endcase
		end
	end

	always_comb begin
		ctrl.advance = advance;
		ctrl.con_bypass = (contrast_gain_q == NEUTRAL_CONTRAST);
		ctrl.gam_bypass = (gamma_setting_q == NEUTRAL_GAMMA);
		ctrl.gain = contrast_gain_q;
		ctrl.bright_add = bright_add_q;
		wr.en = v_s3 && (pix_s3 == 1'b0);
		wr.addr = idx_s3;
		wr.data = val_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			m_valid_q <= v_s4 && pix_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1 <= (s_axis_tuser == OP_PIXEL);
			pix_s2 <= pix_s1;
			pix_s3 <= pix_s2;
			pix_s4 <= pix_s3;
			idx_s1 <= s_axis_tdata[31:24];
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			val_s1 <= s_axis_tdata[39:32];
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			red_s5 <= red_res;
			green_s5 <= green_res;
			blue_s5 <= blue_res;
		end
	end

	pcgb_channel u_red (
		.clk    (clk),
		.ctrl   (ctrl),
		.wr     (wr),
		.pix    (s_axis_tdata[7:0]),
		.result (red_res)
	);

	pcgb_channel u_green (
		.clk    (clk),
		.ctrl   (ctrl),
		.wr     (wr),
		.pix    (s_axis_tdata[15:8]),
		.result (green_res)
	);

	pcgb_channel u_blue (
		.clk    (clk),
		.ctrl   (ctrl),
		.wr     (wr),
		.pix    (s_axis_tdata[23:16]),
		.result (blue_res)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {OPAQUE_ALPHA, blue_s5, green_s5, red_s5};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1 && (pix_s1 == !$past(s_axis_tuser)))
		else $error("accepted transaction did not enter stage 1");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved during output stall");

	a_out_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_valid_q == $past(v_s4 && pix_s4))
		else $error("output valid does not follow a pixel transaction");

	a_no_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && !advance |=> wr.en && $stable(wr.addr))
		else $error("table write lost or changed during stall");

endmodule
`default_nettype wire

@@ src/pcgb_channel.sv @@
// One color channel: contrast multiply/scale, gamma table memory, brightness offset.
`timescale 1ns / 1ps
`default_nettype none
module pcgb_channel
	import pcgb_pkg::*;
(
	input  wire logic            clk,
	input  wire chan_ctrl_t      ctrl,
	input  wire tbl_wr_t         wr,
	input  wire logic [CH_W-1:0] pix,
	output logic      [CH_W-1:0] result
);

	logic [CH_W-1:0] mem [0:TBL_DEPTH-1];

	logic [CH_W-1:0] pix_s1, pix_s2, con_s3, con_s4, rd_s4;
	logic signed [19:0] prod_s2;

	logic signed [9:0] diff;
	logic [16:0] mag;
	logic [9:0] quo;
	logic signed [10:0] sq;
	logic signed [11:0] t;
	logic [CH_W-1:0] con_nxt;
	logic [CH_W-1:0] gam;
	logic signed [10:0] sum;

	assign diff = $signed({2'b00, pix_s1}) - CONTRAST_MID;

	// trunc toward zero: divide the magnitude, then restore the sign
	always_comb begin
		mag = prod_s2[19] ? 17'(-prod_s2) : 17'(prod_s2);
		quo = div100(mag);
		sq = prod_s2[19] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		t = $signed({sq[10], sq}) + 12'sd127;
		if (ctrl.con_bypass) begin
			con_nxt = pix_s2;
		end else if (t < 12'sd0) begin
			con_nxt = '0;
		end else if (t > $signed({4'd0, CH_MAX})) begin
			con_nxt = CH_MAX;
		end else begin
			con_nxt = t[CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			pix_s1 <= pix;
			pix_s2 <= pix_s1;
			prod_s2 <= $signed({{10{diff[9]}}, diff}) * $signed({11'd0, ctrl.gain});
			con_s3 <= con_nxt;
			con_s4 <= con_s3;
		end
	end

	// table writes and lookups both happen at stage 3, so program order holds
	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			rd_s4 <= mem[con_s3];
			if (wr.en) begin
				mem[wr.addr] <= wr.data;
			end
		end
	end

	always_comb begin
		gam = ctrl.gam_bypass ? con_s4 : rd_s4;
		sum = $signed({3'b000, gam}) + $signed({ctrl.bright_add[9], ctrl.bright_add});
		if (sum < 11'sd0) begin
			result = '0;
		end else if (sum > $signed({3'd0, CH_MAX})) begin
			result = CH_MAX;
		end else begin
			result = sum[CH_W-1:0];
		end
	end

endmodule
`default_nettype wire
